>>> hw/rtl/stk_pkg.sv
// Shared types and constants for the stack engine with rotate.
// Used by the controller, the datapath, the top level and the checker.
// Depends on nothing else.
package stk_pkg;

	localparam int unsigned DEPTH_DEF      = 16;
	localparam int unsigned DATA_WIDTH_DEF = 32;

	typedef enum logic [2:0] {
		OP_PUSH = 3'd0,
		OP_POP  = 3'd1,
		OP_PEEK = 3'd2,
		OP_DUP  = 3'd3,
		OP_SWAP = 3'd4,
		OP_ROTR = 3'd5,
		OP_ROTL = 3'd6
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		opcode_t     opcode;
		logic [31:0] push_value;
	} in_item_t;

	typedef struct packed {
		logic [31:0] read_value;
		logic [4:0]  entry_count;
		logic        is_empty;
		status_t     status;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic exec;
	} ctl_t;

endpackage

>>> hw/rtl/stack_engine_with_rotate.sv
// Top level of the stack engine with rotate: joins the controller and the
// datapath. Depends on stk_pkg, stk_ctrl and stk_datapath.
//
// Usage:
//   A command transaction (opcode, push_value) on the cmd channel is taken
//   when cmd_valid is high and cmd_stall is low. Every command gives exactly
//   one result transaction on the rsp channel: the word read, the entry count
//   after the command, an empty flag and a status.
//   A taken command is captured in the command register and executed in
//   state S_EXEC once the output register is free; its result is then
//   registered and rsp_valid rises. The controller takes no new command
//   until that one has executed on the shift-register stack (all cells
//   move at once, the rotates included).
//   While a result waits in the output register, the next command is still
//   taken; it executes only when the receiver takes the waiting result, and
//   cmd_stall stays high until then.
//   Reset clears the entry count, so the stack is empty; the cell contents
//   are undefined but never read before they are written.
module stack_engine_with_rotate #(
	parameter int unsigned DEPTH      = stk_pkg::DEPTH_DEF,
	parameter int unsigned DATA_WIDTH = stk_pkg::DATA_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  stk_pkg::in_item_t  cmd_data,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output stk_pkg::out_item_t rsp_data
);
	import stk_pkg::*;

	ctl_t ctl;

	stk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.ctl       (ctl)
	);

	stk_datapath #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.cmd_data (cmd_data),
		.rsp_data (rsp_data)
	);

endmodule

>>> hw/rtl/stk_ctrl.sv
// Controller for the stack engine: captures a transaction, then executes it
// once the result register is free. Depends on stk_pkg.
module stk_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output stk_pkg::ctl_t ctl
);
	import stk_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   rsp_free;

	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign cmd_stall = (state_q != S_IDLE);
	assign ctl.load  = cmd_valid && (state_q == S_IDLE);
	assign ctl.exec  = (state_q == S_EXEC) && rsp_free;
	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (ctl.load) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (ctl.exec) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (ctl.exec) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> hw/rtl/stk_datapath.sv
// Datapath for the stack engine: a shift-register stack with the top in
// cell zero, the fill count, the command register and the result register.
// Depends on stk_pkg.
module stk_datapath #(
	parameter int unsigned DEPTH      = stk_pkg::DEPTH_DEF,
	parameter int unsigned DATA_WIDTH = stk_pkg::DATA_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  stk_pkg::ctl_t      ctl,
	input  stk_pkg::in_item_t  cmd_data,
	output stk_pkg::out_item_t rsp_data
);
	import stk_pkg::*;

	// Words enter through a 32-bit field, so no more than 32 bits are kept.
	localparam int unsigned CELL_W = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
	localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
	localparam int unsigned IDX_W  = $clog2(DEPTH);

	logic [CELL_W-1:0] cells_q [DEPTH];
	logic [CELL_W-1:0] cells_d [DEPTH];
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  cnt_d;
	logic [CNT_W-1:0]  last;
	logic [IDX_W-1:0]  bot_idx;
	logic [CELL_W-1:0] val;
	logic [CELL_W-1:0] top;
	logic [CELL_W-1:0] bottom;
	logic [CELL_W-1:0] rd;
	logic [31:0]       rd_ext;
	logic [31:0]       cnt_ext;
	logic              full;
	logic              empty;
	logic              many;
	status_t           st;
	in_item_t          cmd_q;
	out_item_t         rsp_q;

	assign val     = cmd_q.push_value[CELL_W-1:0];
	assign top     = cells_q[0];
	assign last    = cnt_q - CNT_W'(1);
	assign bot_idx = last[IDX_W-1:0];
	assign bottom  = cells_q[bot_idx];
	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign many    = (cnt_q >= CNT_W'(2));

	always_comb begin
		cells_d = cells_q;
		cnt_d   = cnt_q;
		rd      = '0;
		st      = ST_OK;
		case (cmd_q.opcode)
			OP_PUSH: begin
				if (full) begin
					st = ST_OVERFLOW;
				end else begin
					cells_d[0] = val;
					for (int i = 1; i < DEPTH; i++) begin
						cells_d[i] = cells_q[i-1];
					end
					cnt_d = cnt_q + CNT_W'(1);
				end
			end
			OP_POP: begin
				if (empty) begin
					st = ST_UNDERFLOW;
				end else begin
					rd = top;
					for (int i = 0; i < DEPTH - 1; i++) begin
						cells_d[i] = cells_q[i+1];
					end
					cnt_d = last;
				end
			end
			OP_PEEK: begin
				if (empty) begin
					st = ST_UNDERFLOW;
				end else begin
					rd = top;
				end
			end
			OP_DUP: begin
				if (empty) begin
					st = ST_UNDERFLOW;
				end else if (full) begin
					st = ST_OVERFLOW;
				end else begin
					rd = top;
					for (int i = 1; i < DEPTH; i++) begin
						cells_d[i] = cells_q[i-1];
					end
					cnt_d = cnt_q + CNT_W'(1);
				end
			end
			OP_SWAP: begin
				if (many) begin
					cells_d[0] = cells_q[1];
					cells_d[1] = cells_q[0];
				end
			end
			OP_ROTR: begin
				// The top word drops to the bottom, the rest move up one cell.
				if (many) begin
					for (int i = 0; i < DEPTH - 1; i++) begin
						if (CNT_W'(i) == last) begin
							cells_d[i] = top;
						end else if (CNT_W'(i) < last) begin
							cells_d[i] = cells_q[i+1];
						end
					end
					if (CNT_W'(DEPTH - 1) == last) begin
						cells_d[DEPTH-1] = top;
					end
				end
			end
			OP_ROTL: begin
				// The bottom word rises to the top, the rest move down one cell.
				if (many) begin
					cells_d[0] = bottom;
					for (int i = 1; i < DEPTH; i++) begin
						if (CNT_W'(i) < cnt_q) begin
							cells_d[i] = cells_q[i-1];
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		rd_ext              = '0;
		rd_ext[CELL_W-1:0]  = rd;
		cnt_ext             = 32'(cnt_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.exec) begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= cmd_data;
		end
		if (ctl.exec) begin
			cells_q             <= cells_d;
			rsp_q.read_value    <= rd_ext;
			rsp_q.entry_count   <= cnt_ext[4:0];
			rsp_q.is_empty      <= (cnt_d == '0);
			rsp_q.status        <= st;
		end
	end

	assign rsp_data = rsp_q;

endmodule

>>> hw/rtl/stk_checker.sv
// Port-level checker for the stack engine with rotate, bound to the top level.
// Depends on stk_pkg and stack_engine_with_rotate.
module stk_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               cmd_valid,
	input logic               cmd_stall,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input stk_pkg::out_item_t rsp_data
);
	import stk_pkg::*;

	// A result held back by the receiver stays put.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
		else $error("stalled result changed or dropped");

	// The engine works on one command at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("command taken while the previous one is still open");

	// A refused command reads nothing.
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status != ST_OK |-> rsp_data.read_value == '0)
		else $error("refused command returned a word");

	// Underflow is only possible on an empty stack, which stays empty.
	a_underflow_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status == ST_UNDERFLOW
		|-> rsp_data.entry_count == '0 && rsp_data.is_empty)
		else $error("underflow reported on a stack that holds entries");

endmodule

bind stack_engine_with_rotate stk_checker u_stk_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_stall (cmd_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp_data  (rsp_data)
);
